// ----- rtl/rmf_pkg.sv -----
// Shared constants and link types for the running median filter.
`default_nettype none

package rmf_pkg;

   localparam int CFG_BITS            = 7;
   localparam int DEF_MAX_WINDOW      = 64;
   localparam int DEF_SAMPLE_BITS     = 16;
   localparam int DEF_WINDOW_LENGTH   = 3;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic push;
      logic clear;
   } rmf_cmd_type;

   // flags a cell hands to its neighbours
   typedef struct packed {
      logic le;      // own value <= new sample
      logic rle;     // entry left here after eviction <= new sample
      logic oldest;  // active entry of age zero
   } rmf_link_type;

endpackage

`default_nettype wire

// ----- rtl/rmf_cell.sv -----
// One cell of the sorted window: value, age and the local evict/insert step.
`default_nettype none

module rmf_cell
   import rmf_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int AGE_BITS    = 6,
   parameter int INDEX       = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire rmf_cmd_type              cmd,
   input  wire        [CFG_BITS-1:0]     len,
   input  wire signed [SAMPLE_BITS-1:0]  push_value,
   input  wire signed [SAMPLE_BITS-1:0]  evict_value,
   input  wire signed [SAMPLE_BITS-1:0]  prev_r_value,
   input  wire        [AGE_BITS-1:0]     prev_r_age,
   input  wire rmf_link_type             prev_link,
   input  wire signed [SAMPLE_BITS-1:0]  next_value,
   input  wire        [AGE_BITS-1:0]     next_age,
   input  wire rmf_link_type             next_link,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic       [AGE_BITS-1:0]     age,
   output rmf_link_type                  link,
   output logic signed [SAMPLE_BITS-1:0] r_value,
   output logic       [AGE_BITS-1:0]     r_age
);

   localparam logic [CFG_BITS-1:0] IDX = CFG_BITS'(INDEX);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic        [AGE_BITS-1:0]    age_ff, age_in;
   logic                          active;
   logic                          is_last;
   logic                          ge;
   logic                          le;
   logic                          rle;

   always_comb begin
      active  = IDX < len;
      is_last = IDX == (len - CFG_BITS'(1));
      // ties are kept oldest first, so the evicted entry is the first one >= its value
      ge      = value_ff >= evict_value;
      le      = value_ff <= push_value;
      r_value = ge ? next_value : value_ff;
      r_age   = (ge ? next_age : age_ff) - AGE_BITS'(1);
      rle     = !is_last && (ge ? next_link.le : le);

      link.le     = le;
      link.rle    = rle;
      link.oldest = active && (age_ff == '0);

      value_in = value_ff;
      age_in   = age_ff;
      if (cmd.clear) begin
         value_in = '0;
         age_in   = AGE_BITS'(INDEX);
      end else if (cmd.push && active) begin
         if (rle) begin
            value_in = r_value;
            age_in   = r_age;
         end else if (prev_link.rle) begin
            value_in = push_value;
            age_in   = AGE_BITS'(len - CFG_BITS'(1));
         end else begin
            value_in = prev_r_value;
            age_in   = prev_r_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= AGE_BITS'(INDEX);
      end else begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

`default_nettype wire

// ----- rtl/rmf_window.sv -----
// Row of sorted window cells, evicted-value register and middle taps.
`default_nettype none

module rmf_window
   import rmf_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire rmf_cmd_type              cmd,
   input  wire        [CFG_BITS-1:0]     len,
   input  wire signed [SAMPLE_BITS-1:0]  push_value,
   output logic signed [SAMPLE_BITS-1:0] mid_lo,
   output logic signed [SAMPLE_BITS-1:0] mid_hi
);

   localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
   logic        [IDX_BITS-1:0]    cell_age   [MAX_WINDOW];
   rmf_link_type                  cell_link  [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_r_value [MAX_WINDOW];
   logic        [IDX_BITS-1:0]    cell_r_age   [MAX_WINDOW];

   logic signed [SAMPLE_BITS-1:0] evict_ff, evict_in;
   logic        [CFG_BITS-1:0]    lo_pos;
   logic        [CFG_BITS-1:0]    hi_pos;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] prev_r_value;
      logic        [IDX_BITS-1:0]    prev_r_age;
      rmf_link_type                  prev_link;
      logic signed [SAMPLE_BITS-1:0] next_value;
      logic        [IDX_BITS-1:0]    next_age;
      rmf_link_type                  next_link;

      if (i == 0) begin : g_head
         // nothing sits below the first cell: insertion there takes the new sample
         assign prev_r_value = '0;
         assign prev_r_age   = '0;
         assign prev_link    = '{le: 1'b1, rle: 1'b1, oldest: 1'b0};
      end else begin : g_mid
         assign prev_r_value = cell_r_value[i-1];
         assign prev_r_age   = cell_r_age[i-1];
         assign prev_link    = cell_link[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign next_value = '0;
         assign next_age   = '0;
         assign next_link  = '{le: 1'b0, rle: 1'b0, oldest: 1'b0};
      end else begin : g_body
         assign next_value = cell_value[i+1];
         assign next_age   = cell_age[i+1];
         assign next_link  = cell_link[i+1];
      end

      rmf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (IDX_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .len          (len),
         .push_value   (push_value),
         .evict_value  (evict_ff),
         .prev_r_value (prev_r_value),
         .prev_r_age   (prev_r_age),
         .prev_link    (prev_link),
         .next_value   (next_value),
         .next_age     (next_age),
         .next_link    (next_link),
         .value        (cell_value[i]),
         .age          (cell_age[i]),
         .link         (cell_link[i]),
         .r_value      (cell_r_value[i]),
         .r_age        (cell_r_age[i])
      );
   end

   // exactly one active cell is oldest, so a plain OR picks its value
   always_comb begin
      evict_in = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (cell_link[i].oldest) begin
            evict_in = evict_in | cell_value[i];
         end
      end
      if (cmd.clear) begin
         evict_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evict_ff <= '0;
      end else begin
         evict_ff <= evict_in;
      end
   end

   always_comb begin
      lo_pos = (len - CFG_BITS'(1)) >> 1;
      hi_pos = len >> 1;
      mid_lo = cell_value[lo_pos[IDX_BITS-1:0]];
      mid_hi = cell_value[hi_pos[IDX_BITS-1:0]];
   end

endmodule

`default_nettype wire

// ----- rtl/running_median_filter.sv -----
// Running median filter top level: control, sample counting and result registers.
//
// Keeps the last window_length samples (1..MAX_WINDOW, 0 reads as 1, larger values
// saturate) in a row of sorted cells; each sample takes a push step, in which
// every cell evicts the oldest entry and inserts the new sample in order
// together with its neighbours, and then a settle state in which the middle taps are
// summed and the value to evict next is registered. The first (n+1)/2-1 samples of a
// column give no result. On end_of_column the block then pushes (n-1)/2 zeros,
// each with its own push and settle step, marks the final median with last_of_column and
// then clears the window in the clear state. A finished median waits in a holding
// register and then in the output register, so one more median can be formed while
// the result side stalls. A csr write sets the window length and clears the window
// and column count at the same edge.
`default_nettype none

module running_median_filter
   import rmf_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [SAMPLE_BITS-1:0] req_sample,
   input  wire                          req_end_of_column,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   output logic                         rsp_last_of_column,
   input  wire                          csr_wr_en,
   input  wire        [CFG_BITS-1:0]    csr_wr_data
);

   localparam logic [CFG_BITS-1:0] MAX_LEN   = CFG_BITS'(MAX_WINDOW);
   localparam logic [CFG_BITS-1:0] RESET_LEN =
      (DEF_WINDOW_LENGTH > MAX_WINDOW) ? CFG_BITS'(MAX_WINDOW) : CFG_BITS'(DEF_WINDOW_LENGTH);
   localparam logic [CFG_BITS-1:0] SEEN_MAX  = {CFG_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_PAD,
      ST_CLEAR
   } state_type;

   state_type                     state_ff, state_in;
   logic        [CFG_BITS-1:0]    len_ff, len_in;
   logic        [CFG_BITS-1:0]    seen_ff, seen_in;
   logic        [CFG_BITS-2:0]    pad_left_ff, pad_left_in;
   logic                          eoc_ff, eoc_in;
   logic                          due_ff, due_in;
   logic signed [SAMPLE_BITS-1:0] med_ff, med_in;
   logic                          med_last_ff, med_last_in;
   logic                          med_valid_ff, med_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   rmf_cmd_type                   cmd;
   logic signed [SAMPLE_BITS-1:0] push_value;
   logic signed [SAMPLE_BITS-1:0] mid_lo;
   logic signed [SAMPLE_BITS-1:0] mid_hi;
   logic signed [SAMPLE_BITS:0]   mid_sum;
   logic        [CFG_BITS-1:0]    threshold;
   logic        [CFG_BITS-1:0]    pad_count;
   logic        [CFG_BITS-1:0]    csr_len;
   logic                          med_move;
   logic                          slot_free;
   logic                          take;

   rmf_window #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .len        (len_ff),
      .push_value (push_value),
      .mid_lo     (mid_lo),
      .mid_hi     (mid_hi)
   );

   always_comb begin
      med_move  = med_valid_ff && (!rsp_valid_ff || rsp_ready);
      slot_free = !med_valid_ff || med_move;
      req_ready = (state_ff == ST_IDLE) && slot_free;
      take      = req_valid && req_ready;

      threshold = ((len_ff + CFG_BITS'(1)) >> 1) - CFG_BITS'(1);
      pad_count = (len_ff - CFG_BITS'(1)) >> 1;
      // arithmetic halving of the widened sum floors the mean
      mid_sum   = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};

      if (csr_wr_data == '0) begin
         csr_len = CFG_BITS'(1);
      end else if (csr_wr_data > MAX_LEN) begin
         csr_len = MAX_LEN;
      end else begin
         csr_len = csr_wr_data;
      end

      cmd.push   = take || ((state_ff == ST_PAD) && slot_free);
      cmd.clear  = (state_ff == ST_CLEAR) || csr_wr_en;
      push_value = (state_ff == ST_IDLE) ? req_sample : '0;

      state_in     = state_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      pad_left_in  = pad_left_ff;
      eoc_in       = eoc_ff;
      due_in       = due_ff;
      med_in       = med_ff;
      med_last_in  = med_last_ff;
      med_valid_in = med_valid_ff;

      if (med_move) begin
         med_valid_in = 1'b0;
      end

      if (cmd.push) begin
         due_in = seen_ff >= threshold;
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + CFG_BITS'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               eoc_in      = req_end_of_column;
               pad_left_in = req_end_of_column ? pad_count[CFG_BITS-2:0] : '0;
               state_in    = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if (due_ff) begin
               med_valid_in = 1'b1;
               med_in       = mid_sum[SAMPLE_BITS:1];
               med_last_in  = eoc_ff && (pad_left_ff == '0);
            end
            if (pad_left_ff != '0) begin
               state_in = ST_PAD;
            end else if (eoc_ff) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               pad_left_in = pad_left_ff - (CFG_BITS-1)'(1);
               state_in    = ST_SETTLE;
            end
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.clear) begin
         seen_in = '0;
      end
      if (csr_wr_en) begin
         len_in = csr_len;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_last_in   = rsp_last_ff;
      if (med_move) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = med_ff;
         rsp_last_in   = med_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= RESET_LEN;
         seen_ff      <= '0;
         pad_left_ff  <= '0;
         eoc_ff       <= 1'b0;
         due_ff       <= 1'b0;
         med_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         pad_left_ff  <= pad_left_in;
         eoc_ff       <= eoc_in;
         due_ff       <= due_in;
         med_valid_ff <= med_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      med_ff        <= med_in;
      med_last_ff   <= med_last_in;
      rsp_median_ff <= rsp_median_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median         = rsp_median_ff;
   assign rsp_last_of_column = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/running_median_filter_test.sv -----
// Self-checking testbench for the running median filter: directed and random sample streams.
`default_nettype none

module running_median_filter_test
   import rmf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
   localparam int MAX_WINDOW  = DEF_MAX_WINDOW;
   // longest item: a padded column end, plus output registers
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] median;
      logic                          last_col;
   } median_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_end_of_column;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_median;
   logic                          rsp_last_of_column;
   logic                          csr_wr_en;
   logic [CFG_BITS-1:0]           csr_wr_data;

   median_type    expected_medians[$];
   int            error_count;
   int            sender_idle_pct;
   int            recv_stall_pct;

   // predictor state
   logic [CFG_BITS-1:0] cfg_len;
   int                  window_vals[MAX_WINDOW];
   int                  window_ages[MAX_WINDOW];
   int                  column_count;

   running_median_filter #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_end_of_column  (req_end_of_column),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median         (rsp_median),
      .rsp_last_of_column (rsp_last_of_column),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------- predictor ----------------

   function automatic int active_len();
      if (cfg_len == 0)
         return 1;
      if (cfg_len > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(cfg_len);
   endfunction

   function automatic void reset_window();
      int i;
      for (i = 0; i < MAX_WINDOW; i++) begin
         window_vals[i] = 0;
         window_ages[i] = i;
      end
      column_count = 0;
   endfunction

   // evict the oldest entry, then insert v in sorted position as the newest
   function automatic void insert_sample(int v);
      int  n;
      int  p;
      int  q;
      int  i;
      bit  found;
      n = active_len();
      p = n - 1;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
         if (!found && window_ages[i] == 0) begin
            p = i;
            found = 1'b1;
         end
      end
      for (i = p; i + 1 < n; i++) begin
         window_vals[i] = window_vals[i+1];
         window_ages[i] = window_ages[i+1];
      end
      for (i = 0; i + 1 < n; i++) begin
         if (window_ages[i] > 0)
            window_ages[i]--;
      end
      q = 0;
      while (q + 1 < n && window_vals[q] < v)
         q++;
      for (i = n - 1; i > q; i--) begin
         window_vals[i] = window_vals[i-1];
         window_ages[i] = window_ages[i-1];
      end
      window_vals[q] = v;
      window_ages[q] = n - 1;
      if (column_count < 127)
         column_count++;
   endfunction

   function automatic int centre_value();
      int n;
      int sum;
      n = active_len();
      if (n % 2 == 1)
         return window_vals[(n-1)/2];
      sum = window_vals[n/2-1] + window_vals[n/2];
      return sum >>> 1;  // floored mean
   endfunction

   function automatic bit take_sample(int v);
      int         n;
      int         seen;
      median_type r;
      n = active_len();
      seen = column_count;
      insert_sample(v);
      if (seen >= (n + 1) / 2 - 1) begin
         r.median = SAMPLE_BITS'(centre_value());
         r.last_col = 1'b0;
         expected_medians.push_back(r);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_item(logic signed [SAMPLE_BITS-1:0] s, logic eoc);
      int n;
      int k;
      int produced;
      n = active_len();
      produced = 0;
      if (take_sample(int'(s)))
         produced++;
      if (eoc) begin
         for (k = 0; k < (n - 1) / 2; k++) begin
            if (take_sample(0))
               produced++;
         end
         if (produced > 0)
            expected_medians[expected_medians.size()-1].last_col = 1'b1;
         reset_window();
      end
   endfunction

   // ---------------- result side ----------------

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      median_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_medians.size() == 0) begin
            $error("unexpected result transfer: median %0d last_of_column %0b",
                   rsp_median, rsp_last_of_column);
            error_count++;
         end else begin
            exp_r = expected_medians.pop_front();
            if (rsp_median !== exp_r.median) begin
               $error("median: expected %0d, actual %0d", exp_r.median, rsp_median);
               error_count++;
            end
            if (rsp_last_of_column !== exp_r.last_col) begin
               $error("last_of_column: expected %0b, actual %0b",
                      exp_r.last_col, rsp_last_of_column);
               error_count++;
            end
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic eoc);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_sample        <= s;
      req_end_of_column <= eoc;
      do
         @(posedge clock);
      while (!req_ready);
      predict_item(s, eoc);
   endtask

   // all results in and the block quiet
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_medians.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [CFG_BITS-1:0] len);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_len = len;
      reset_window();
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample(
      logic signed [SAMPLE_BITS-1:0] prev);
      case ($urandom_range(0, 5))
         0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2: return prev;  // ties in the sorted window
         3: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_BITS-1:0] random_window();
      case ($urandom_range(0, 9))
         0: return CFG_BITS'($urandom_range(MAX_WINDOW, 127));
         1: return '0;
         2: return CFG_BITS'($urandom_range(13, MAX_WINDOW));
         default: return CFG_BITS'($urandom_range(1, 12));
      endcase
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_window();
      // reset length of three, field extremes
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh0001, 1'b1);
   endtask

   task automatic test_unit_window();
      write_window(CFG_BITS'(1));
      send_sample(-16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);
   endtask

   task automatic test_zero_length();
      write_window('0);
      send_sample(16'sh1234, 1'b0);
      send_sample(-16'sh0005, 1'b1);
   endtask

   task automatic test_even_window();
      // floored mean of the middle pair, sum beyond sample range
      write_window(CFG_BITS'(2));
      send_sample(-16'sh0003, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(-16'sh8000, 1'b1);
      write_window(CFG_BITS'(4));
      send_sample(-16'sh0007, 1'b0);
      send_sample(16'sh0002, 1'b1);
   endtask

   task automatic test_saturated_length();
      write_window(CFG_BITS'(127));
      send_sample(16'sh0100, 1'b0);
      send_sample(-16'sh0100, 1'b1);
      write_window(CFG_BITS'(MAX_WINDOW));
      send_sample(16'sh7fff, 1'b1);
      write_window(CFG_BITS'(MAX_WINDOW + 1));
      send_sample(-16'sh8000, 1'b1);
   endtask

   task automatic test_short_column();
      // column shorter than the window, no clipping
      write_window(CFG_BITS'(9));
      send_sample(16'sh0040, 1'b0);
      send_sample(16'sh0020, 1'b1);
   endtask

   task automatic test_write_clears();
      // no median due for the first samples; a write mid-column restarts it
      write_window(CFG_BITS'(5));
      send_sample(16'sh0011, 1'b0);
      send_sample(16'sh0022, 1'b0);
      send_sample(16'sh0033, 1'b0);
      write_window(CFG_BITS'(5));
      send_sample(-16'sh0044, 1'b0);
      send_sample(16'sh0055, 1'b1);
   endtask

   task automatic test_long_column();
      // column count must hold at its top value rather than wrap
      logic signed [SAMPLE_BITS-1:0] s;
      int i;
      write_window(CFG_BITS'(7));
      s = '0;
      for (i = 0; i < 130; i++) begin
         s = random_sample(s);
         send_sample(s, i == 129);
      end
   endtask

   task automatic test_random_columns(int idle_pct, int stall_pct, int count);
      logic signed [SAMPLE_BITS-1:0] s;
      int sent;
      int burst;
      int i;
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      s = '0;
      sent = 0;
      while (sent < count) begin
         write_window(random_window());
         burst = $urandom_range(5, 15);
         if (burst > count - sent)
            burst = count - sent;
         for (i = 0; i < burst; i++) begin
            s = random_sample(s);
            send_sample(s, $urandom_range(0, 4) == 0);
         end
         sent += burst;
      end
   endtask

   initial begin
      error_count       = 0;
      sender_idle_pct   = 0;
      recv_stall_pct    = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample        = '0;
      req_end_of_column = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      cfg_len           = CFG_BITS'(DEF_WINDOW_LENGTH);
      reset_window();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_unit_window();
      test_zero_length();
      test_even_window();
      test_saturated_length();
      test_short_column();
      test_write_clears();
      sender_idle_pct = 0;
      recv_stall_pct  = 20;
      test_long_column();
      test_random_columns(0, 0, 6);
      test_random_columns(61, 0, 6);
      test_random_columns(0, 61, 6);
      test_random_columns(20, 20, 6);

      wait_idle();
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
